// ===== rtl/rdsgbg_pkg.sv =====
// Package for the RDS group bitstream generator: shared types, operation
// codes, register indexes, CRC and offset constants, fixed group contents.
// No dependencies.
package rdsgbg_pkg;

   localparam int unsigned CELLS = 16;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_PS   = 2'd1;
   localparam logic [1:0] OP_RT   = 2'd2;

   localparam logic [2:0] CSR_PI_CODE    = 3'd0;
   localparam logic [2:0] CSR_PTY        = 3'd1;
   localparam logic [2:0] CSR_TP         = 3'd2;
   localparam logic [2:0] CSR_TA         = 3'd3;
   localparam logic [2:0] CSR_MS         = 3'd4;
   localparam logic [2:0] CSR_ECC_ENABLE = 3'd5;
   localparam logic [2:0] CSR_ECC_VALUE  = 3'd6;
   localparam logic [2:0] CSR_TMC_ENABLE = 3'd7;

   localparam logic [9:0] CRC_POLY_LOW = 10'h1B9;
   localparam logic [9:0] OFFSET_A     = 10'h0FC;
   localparam logic [9:0] OFFSET_B     = 10'h198;
   localparam logic [9:0] OFFSET_C     = 10'h168;
   localparam logic [9:0] OFFSET_D     = 10'h1B4;

   localparam logic [4:0] BLOCK_LAST_BIT = 5'd25;
   localparam logic [4:0] BASE_SLOTS     = 5'd21;
   localparam logic [7:0] SPACE_CHAR     = 8'h20;

   localparam logic [15:0] TMC_C_FIRST  = 16'h0066;
   localparam logic [15:0] TMC_C_SECOND = 16'h6280;
   localparam logic [15:0] TMC_AID      = 16'hCD46;
   localparam logic [15:0] TMC_EVENT    = 16'h953C;
   localparam logic [15:0] TMC_LOCATION = 16'h2B0F;
   localparam logic [15:0] ODA_C_WORD   = 16'h2038;
   localparam logic [15:0] ODA_D_WORD   = 16'h4456;

   typedef struct packed {
      logic [15:0] pi_code;
      logic [4:0]  program_type;
      logic        traffic_program;
      logic        traffic_announce;
      logic        music_speech;
      logic        ecc_enable;
      logic [7:0]  ecc_value;
      logic        tmc_enable;
   } cfg_type;

   typedef struct packed {
      logic [15:0] word;
      logic        use_rt;
      logic [1:0]  blk;
      logic [4:0]  rbit;
   } front_type;

   typedef struct packed {
      logic [15:0] word;
      logic [9:0]  rem;
      logic [1:0]  blk;
      logic [4:0]  rbit;
   } cell_type;

endpackage

// ===== rtl/rds_group_bitstream_generator_top.sv =====
// RDS group bitstream generator, top level. A tick item accepted by the front
// register passes through 16 check cells and the output register to give its
// bit. Throughput: one item per cycle while rsp_stall lets the output move;
// back-pressure holds the chain and raises req_stall. Writes give no result.
// Reset (synchronous): counters, registers and pipeline clear, text reads as
// spaces. Depends on rdsgbg_pkg, rdsgbg_seq, rdsgbg_rt_mem, rdsgbg_crc_cell.
module rds_group_bitstream_generator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [5:0]  req_char_index,
   input  logic [7:0]  req_char_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_bit_out,
   output logic        rsp_group_start,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import rdsgbg_pkg::*;

   cfg_type     cfg_ff;
   front_type   front;
   front_type   s1_ff;
   logic        s1_valid_ff;
   logic        s1_ready;
   logic [4:0]  rt_row;
   logic [15:0] rt_word;
   logic        accept;
   logic        tick;

   cell_type         cin  [CELLS];
   cell_type         cout [CELLS];
   logic [CELLS-1:0] cin_v;
   logic [CELLS-1:0] cout_v;
   logic [CELLS:0]   rdy;

   logic        rsp_valid_ff;
   logic        bit_ff;
   logic        start_ff;
   logic        out_ready;
   logic [25:0] full;
   logic [9:0]  offset;
   logic [4:0]  sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PI_CODE:    cfg_ff.pi_code          <= csr_wdata;
            CSR_PTY:        cfg_ff.program_type     <= csr_wdata[4:0];
            CSR_TP:         cfg_ff.traffic_program  <= csr_wdata[0];
            CSR_TA:         cfg_ff.traffic_announce <= csr_wdata[0];
            CSR_MS:         cfg_ff.music_speech     <= csr_wdata[0];
            CSR_ECC_ENABLE: cfg_ff.ecc_enable       <= csr_wdata[0];
            CSR_ECC_VALUE:  cfg_ff.ecc_value        <= csr_wdata[7:0];
            CSR_TMC_ENABLE: cfg_ff.tmc_enable       <= csr_wdata[0];
            default:        cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign rdy[CELLS] = out_ready;
   assign s1_ready   = !s1_valid_ff || rdy[0];
   assign req_stall  = !s1_ready;
   assign accept     = req_valid && s1_ready;
   assign tick       = accept && (req_op == OP_TICK);

   rdsgbg_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .op         (req_op),
      .char_index (req_char_index),
      .char_value (req_char_value),
      .cfg        (cfg_ff),
      .front      (front),
      .rt_row     (rt_row)
   );

   rdsgbg_rt_mem u_rt_mem (
      .clock (clock),
      .reset (reset),
      .we    (accept && (req_op == OP_RT)),
      .waddr (req_char_index),
      .wdata (req_char_value),
      .re    (tick),
      .raddr (rt_row),
      .rword (rt_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= tick;
      end
   end

   always_ff @(posedge clock) begin
      if (tick) begin
         s1_ff <= front;
      end
   end

   assign cin[0]   = {s1_ff.use_rt ? rt_word : s1_ff.word, 10'd0, s1_ff.blk, s1_ff.rbit};
   assign cin_v[0] = s1_valid_ff;

   for (genvar g = 0; g < CELLS; g++) begin : g_cell
      if (g > 0) begin : g_link
         assign cin[g]   = cout[g-1];
         assign cin_v[g] = cout_v[g-1];
      end
      rdsgbg_crc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (cin_v[g]),
         .up_data    (cin[g]),
         .up_ready   (rdy[g]),
         .down_ready (rdy[g+1]),
         .down_valid (cout_v[g]),
         .down_data  (cout[g])
      );
   end

   always_comb begin
      unique case (cout[CELLS-1].blk)
         2'd0:    offset = OFFSET_A;
         2'd1:    offset = OFFSET_B;
         2'd2:    offset = OFFSET_C;
         default: offset = OFFSET_D;
      endcase
      full = {cout[CELLS-1].word, cout[CELLS-1].rem} ^ {16'd0, offset};
      sel  = BLOCK_LAST_BIT - cout[CELLS-1].rbit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= cout_v[CELLS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && cout_v[CELLS-1]) begin
         bit_ff   <= full[sel];
         start_ff <= (cout[CELLS-1].blk == 2'd0) && (cout[CELLS-1].rbit == 5'd0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bit_out     = bit_ff;
   assign rsp_group_start = start_ff;

endmodule

// ===== rtl/rdsgbg_rt_mem.sv =====
// Radiotext store: 32 rows of two characters, byte writes, registered read.
// Per-character valid bits make unwritten characters read as spaces.
// Depends on rdsgbg_pkg.
module rdsgbg_rt_mem (
   input  logic        clock,
   input  logic        reset,
   input  logic        we,
   input  logic [5:0]  waddr,
   input  logic [7:0]  wdata,
   input  logic        re,
   input  logic [4:0]  raddr,
   output logic [15:0] rword
);
   import rdsgbg_pkg::*;

   logic [15:0] mem [32];
   logic [63:0] valid_ff;
   logic [15:0] rd_ff;
   logic [1:0]  rdv_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         if (waddr[0]) begin
            mem[waddr[5:1]][7:0] <= wdata;
         end else begin
            mem[waddr[5:1]][15:8] <= wdata;
         end
      end
      if (re) begin
         rd_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rdv_ff   <= '0;
      end else begin
         if (we) begin
            valid_ff[waddr] <= 1'b1;
         end
         if (re) begin
            rdv_ff <= {valid_ff[{raddr, 1'b0}], valid_ff[{raddr, 1'b1}]};
         end
      end
   end

   assign rword = {rdv_ff[1] ? rd_ff[15:8] : SPACE_CHAR,
                   rdv_ff[0] ? rd_ff[7:0]  : SPACE_CHAR};

endmodule

// ===== rtl/rdsgbg_crc_cell.sv =====
// One cell of the check-word chain: folds one message bit into the
// remainder and rotates the word for the next cell. Depends on rdsgbg_pkg.
module rdsgbg_crc_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   input  rdsgbg_pkg::cell_type up_data,
   output logic                 up_ready,
   input  logic                 down_ready,
   output logic                 down_valid,
   output rdsgbg_pkg::cell_type down_data
);
   import rdsgbg_pkg::*;

   logic     valid_ff;
   cell_type data_ff;
   cell_type step_in;
   logic     fb;

   assign up_ready = !valid_ff || down_ready;

   always_comb begin
      fb           = up_data.rem[9] ^ up_data.word[15];
      step_in      = up_data;
      step_in.rem  = {up_data.rem[8:0], 1'b0} ^ (fb ? CRC_POLY_LOW : 10'd0);
      step_in.word = {up_data.word[14:0], up_data.word[15]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= step_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;

endmodule

// ===== rtl/rdsgbg_seq.sv =====
// Group sequencer: slot and bit counters, programme service name store and
// the information word for the current bit. Depends on rdsgbg_pkg.
module rdsgbg_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [1:0]            op,
   input  logic [5:0]            char_index,
   input  logic [7:0]            char_value,
   input  rdsgbg_pkg::cfg_type   cfg,
   output rdsgbg_pkg::front_type front,
   output logic [4:0]            rt_row
);
   import rdsgbg_pkg::*;

   logic [4:0]  slot_ff, slot_in;
   logic [1:0]  blk_ff, blk_in;
   logic [4:0]  rbit_ff, rbit_in;
   logic [15:0] ps_ff [4];
   logic        tick;
   logic        last;
   logic [4:0]  seq_len;
   logic [4:0]  slot_eff;
   logic [4:0]  slot_next;

   assign tick      = accept && (op == OP_TICK);
   assign seq_len   = BASE_SLOTS + {4'd0, cfg.ecc_enable} + (cfg.tmc_enable ? 5'd3 : 5'd0);
   assign slot_eff  = (slot_ff >= seq_len) ? 5'd0 : slot_ff;
   assign slot_next = slot_eff + 5'd1;
   assign last      = (blk_ff == 2'd3) && (rbit_ff == BLOCK_LAST_BIT);

   always_comb begin
      rbit_in = (rbit_ff == BLOCK_LAST_BIT) ? 5'd0 : rbit_ff + 5'd1;
      blk_in  = (rbit_ff == BLOCK_LAST_BIT) ? blk_ff + 2'd1 : blk_ff;
      slot_in = slot_eff;
      if (last) begin
         slot_in = (slot_next >= seq_len) ? 5'd0 : slot_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         blk_ff  <= '0;
         rbit_ff <= '0;
      end else if (tick) begin
         slot_ff <= slot_in;
         blk_ff  <= blk_in;
         rbit_ff <= rbit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            ps_ff[i] <= {SPACE_CHAR, SPACE_CHAR};
         end
      end else if (accept && (op == OP_PS) && (char_index[5:3] == 3'd0)) begin
         if (char_index[0]) begin
            ps_ff[char_index[2:1]][7:0] <= char_value;
         end else begin
            ps_ff[char_index[2:1]][15:8] <= char_value;
         end
      end
   end

   always_comb begin
      logic        is0a, is1a, is2a, is3a, is8a;
      logic [4:0]  t1, t2, t3;
      logic [10:0] base;
      logic [15:0] w1, w2, w3;
      logic        rt_c;
      base = {cfg.traffic_program, cfg.program_type, 5'd0};
      t1   = slot_eff - 5'd4;
      t2   = t1 - {4'd0, cfg.ecc_enable};
      t3   = t2 - 5'd16;
      is0a = slot_eff < 5'd4;
      is1a = !is0a && cfg.ecc_enable && (t1 == 5'd0);
      is2a = !is0a && !is1a && (t2 < 5'd16);
      is3a = !is0a && !is1a && !is2a && cfg.tmc_enable && (t3 < 5'd2);
      is8a = !is0a && !is1a && !is2a && cfg.tmc_enable && (t3 == 5'd2);
      rt_c = 1'b0;
      if (is0a) begin
         w1 = {5'd0, cfg.traffic_program, cfg.program_type, cfg.traffic_announce,
               cfg.music_speech, slot_eff[1:0] == 2'd3, slot_eff[1:0]};
         w2 = cfg.pi_code;
         w3 = ps_ff[slot_eff[1:0]];
      end else if (is1a) begin
         w1 = {4'd1, 1'b0, base};
         w2 = {8'h80, cfg.ecc_value};
         w3 = 16'd0;
      end else if (is2a) begin
         w1 = {4'd2, 1'b0, base[10:5], 1'b0, t2[3:0]};
         w2 = 16'd0;
         w3 = 16'd0;
         rt_c = 1'b1;
      end else if (is3a) begin
         w1 = {4'd3, 1'b0, base[10:5], 5'h10};
         w2 = (t3 == 5'd0) ? TMC_C_FIRST : TMC_C_SECOND;
         w3 = TMC_AID;
      end else if (is8a) begin
         w1 = {4'd8, 1'b0, base[10:5], 5'h0B};
         w2 = TMC_EVENT;
         w3 = TMC_LOCATION;
      end else begin
         w1 = {4'd11, 1'b0, base[10:5], 5'h08};
         w2 = ODA_C_WORD;
         w3 = ODA_D_WORD;
      end
      front.blk    = blk_ff;
      front.rbit   = rbit_ff;
      front.use_rt = rt_c && (blk_ff[1] == 1'b1);
      unique case (blk_ff)
         2'd0:    front.word = cfg.pi_code;
         2'd1:    front.word = w1;
         2'd2:    front.word = w2;
         default: front.word = w3;
      endcase
      rt_row = {t2[3:0], blk_ff[0]};
   end

`ifndef SYNTH
   a_bit_advance: assert property (@(posedge clock) disable iff (reset)
      tick && (rbit_ff != BLOCK_LAST_BIT) |=> rbit_ff == $past(rbit_ff) + 5'd1)
      else $error("bit counter did not advance");
   a_group_wrap: assert property (@(posedge clock) disable iff (reset)
      tick && last |=> (blk_ff == 2'd0) && (rbit_ff == 5'd0))
      else $error("group end did not wrap the bit counters");
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !tick |=> $stable(slot_ff) && $stable(blk_ff) && $stable(rbit_ff))
      else $error("counters moved without a tick");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for rds_group_bitstream_generator_top: directed table,
// then phased random items, most phases with idling on both sides, checked bit by bit.
// Depends on rdsgbg_pkg and the generator RTL.
`timescale 1ns / 100ps

module tb_top;
   import rdsgbg_pkg::*;

   localparam int unsigned GROUP_BITS  = 104;
   localparam int unsigned BLOCK_BITS  = 26;
   localparam int unsigned PS_CHARS    = 8;
   localparam int unsigned N_DIRECTED  = 20;
   localparam int unsigned PHASES      = 6;
   localparam int unsigned PHASE_ITEMS = 255;
   localparam int unsigned DRAIN_WAIT  = 40;

   localparam logic [1:0]  OP_UNUSED   = 2'd3;

   localparam logic [3:0]  GT_ECC       = 4'd1;
   localparam logic [3:0]  GT_RT        = 4'd2;
   localparam logic [3:0]  GT_TMC       = 4'd3;
   localparam logic [3:0]  GT_TMC_EVENT = 4'd8;
   localparam logic [3:0]  GT_ODA       = 4'd11;
   localparam logic [15:0] DI_BITS      = 16'h0005;
   localparam logic [15:0] ECC_VARIANT  = 16'h8000;
   localparam logic [15:0] TMC_B_LOW    = 16'h0010;
   localparam logic [15:0] EVENT_B_LOW  = 16'h000B;
   localparam logic [15:0] ODA_B_LOW    = 16'h0008;

   typedef enum logic [1:0] {
      CHECK_MODEL,
      CHECK_BIT,
      CHECK_NONE
   } check_kind_type;

   typedef struct packed {
      logic bit_out;
      logic group_start;
   } rds_bit_type;

   typedef struct packed {
      logic [1:0]     op;
      logic [5:0]     idx;
      logic [7:0]     val;
      check_kind_type kind;
      logic           exp_bit;
      logic           exp_gs;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_op;
   logic [5:0]  req_char_index;
   logic [7:0]  req_char_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_bit_out;
   logic        rsp_group_start;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   cfg_type     cfg_shadow;
   logic [7:0]  ps_chars [0:7];
   logic [7:0]  rt_chars [0:63];
   logic [4:0]  slot_now;
   logic [6:0]  bitpos_now;

   rds_bit_type pending_bits [$];
   rds_bit_type seen_bit;
   int unsigned fail_count;
   bit          req_calm;
   bit          rsp_calm;

   rds_group_bitstream_generator_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_char_index  (req_char_index),
      .req_char_value  (req_char_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_bit_out     (rsp_bit_out),
      .rsp_group_start (rsp_group_start),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #60_000_000;
      $display("tb_top failed");
      $finish;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [9:0] check_bits(logic [15:0] word);
      logic [10:0] acc;
      int          i;
      acc = '0;
      for (i = 15; i >= 0; i--) begin
         acc = {acc[9:0], word[i]};
         if (acc[10]) acc = acc ^ {1'b1, CRC_POLY_LOW};
      end
      for (i = 0; i < 10; i++) begin
         acc = {acc[9:0], 1'b0};
         if (acc[10]) acc = acc ^ {1'b1, CRC_POLY_LOW};
      end
      return acc[9:0];
   endfunction

   function automatic logic [4:0] seq_slots();
      return BASE_SLOTS + 5'(cfg_shadow.ecc_enable) + 5'(3 * cfg_shadow.tmc_enable);
   endfunction

   function automatic logic [3:0][15:0] group_words(logic [4:0] slot);
      logic [3:0][15:0] w;
      logic [15:0]      base;
      int unsigned      s;
      int unsigned      p;
      base = {5'd0, cfg_shadow.traffic_program, cfg_shadow.program_type, 5'd0};
      s = slot;
      w[0] = cfg_shadow.pi_code;
      if (s < 4) begin
         w[1] = base | {11'd0, cfg_shadow.traffic_announce, cfg_shadow.music_speech, 3'd0}
                | 16'(s);
         if (s == 3) w[1] = w[1] | DI_BITS;
         w[2] = cfg_shadow.pi_code;
         w[3] = {ps_chars[2 * s], ps_chars[2 * s + 1]};
         return w;
      end
      s = s - 4;
      if (cfg_shadow.ecc_enable) begin
         if (s == 0) begin
            w[1] = {GT_ECC, 12'd0} | base;
            w[2] = ECC_VARIANT | {8'd0, cfg_shadow.ecc_value};
            w[3] = '0;
            return w;
         end
         s = s - 1;
      end
      if (s < 16) begin
         p = 4 * s;
         w[1] = {GT_RT, 12'd0} | base | 16'(s);
         w[2] = {rt_chars[p], rt_chars[p + 1]};
         w[3] = {rt_chars[p + 2], rt_chars[p + 3]};
         return w;
      end
      s = s - 16;
      if (cfg_shadow.tmc_enable && s < 2) begin
         w[1] = {GT_TMC, 12'd0} | base | TMC_B_LOW;
         w[2] = (s == 0) ? TMC_C_FIRST : TMC_C_SECOND;
         w[3] = TMC_AID;
      end else if (cfg_shadow.tmc_enable && s == 2) begin
         w[1] = {GT_TMC_EVENT, 12'd0} | base | EVENT_B_LOW;
         w[2] = TMC_EVENT;
         w[3] = TMC_LOCATION;
      end else begin
         w[1] = {GT_ODA, 12'd0} | base | ODA_B_LOW;
         w[2] = ODA_C_WORD;
         w[3] = ODA_D_WORD;
      end
      return w;
   endfunction

   task automatic advance_encoder(input logic [1:0] op, input logic [5:0] idx,
                                  input logic [7:0] val, output logic emits,
                                  output rds_bit_type res);
      logic [3:0][15:0] w;
      logic [1:0]       blk;
      logic [4:0]       pos;
      logic [9:0]       offs;
      logic [25:0]      frame;
      emits = 1'b0;
      res = '0;
      case (op)
         OP_PS: begin
            if (idx < PS_CHARS) ps_chars[idx[2:0]] = val;
         end
         OP_RT: begin
            rt_chars[idx] = val;
         end
         OP_TICK: begin
            if (slot_now >= seq_slots()) slot_now = '0;
            if (bitpos_now >= GROUP_BITS) bitpos_now = '0;
            w = group_words(slot_now);
            blk = 2'(bitpos_now / BLOCK_BITS);
            pos = 5'(bitpos_now % BLOCK_BITS);
            case (blk)
               2'd0: offs = OFFSET_A;
               2'd1: offs = OFFSET_B;
               2'd2: offs = OFFSET_C;
               default: offs = OFFSET_D;
            endcase
            frame = {w[blk], check_bits(w[blk])} ^ {16'd0, offs};
            res.bit_out = frame[BLOCK_LAST_BIT - pos];
            res.group_start = (bitpos_now == 0);
            emits = 1'b1;
            bitpos_now = bitpos_now + 7'd1;
            if (bitpos_now >= GROUP_BITS) begin
               bitpos_now = '0;
               slot_now = slot_now + 5'd1;
               if (slot_now >= seq_slots()) slot_now = '0;
            end
         end
         default: ;
      endcase
   endtask

   // Call at a rising edge; returns at the edge that accepts the item.
   task automatic send_item(input logic [1:0] op, input logic [5:0] idx, input logic [7:0] val,
                            input check_kind_type kind, input logic exp_bit,
                            input logic exp_gs);
      int unsigned gap;
      logic        emits;
      rds_bit_type res;
      gap = req_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_char_index <= idx;
      req_char_value <= val;
      do @(posedge clock); while (req_stall);
      advance_encoder(op, idx, val, emits, res);
      if (kind == CHECK_BIT) pending_bits.push_back('{bit_out: exp_bit, group_start: exp_gs});
      else if (kind == CHECK_MODEL && emits) pending_bits.push_back(res);
   endtask

   task automatic send_random_item();
      int unsigned r;
      logic [1:0]  op;
      logic [5:0]  idx;
      r = $urandom_range(0, 99);
      idx = 6'($urandom);
      if (r < 84) op = OP_TICK;
      else if (r < 91) begin
         op = OP_PS;
         if ($urandom_range(0, 1)) idx = 6'($urandom_range(0, PS_CHARS - 1));
      end else if (r < 98) op = OP_RT;
      else op = OP_UNUSED;
      send_item(op, idx, 8'($urandom), CHECK_MODEL, 1'b0, 1'b0);
   endtask

   // Hold off until every bit is back and the pipeline has emptied.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_bits.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic program_settings(input cfg_type c);
      logic [15:0] wdata;
      logic [15:0] value;
      int          n;
      for (n = 0; n < 8; n++) begin
         wdata = 16'($urandom);
         case (3'(n))
            CSR_PI_CODE:    value = c.pi_code;
            CSR_PTY:        value = {11'd0, c.program_type};
            CSR_TP:         value = {15'd0, c.traffic_program};
            CSR_TA:         value = {15'd0, c.traffic_announce};
            CSR_MS:         value = {15'd0, c.music_speech};
            CSR_ECC_ENABLE: value = {15'd0, c.ecc_enable};
            CSR_ECC_VALUE:  value = {8'd0, c.ecc_value};
            default:        value = {15'd0, c.tmc_enable};
         endcase
         case (3'(n))
            CSR_PI_CODE:   wdata = value;
            CSR_PTY:       wdata[4:0] = value[4:0];
            CSR_ECC_VALUE: wdata[7:0] = value[7:0];
            default:       wdata[0] = value[0];
         endcase
         csr_we    <= 1'b1;
         csr_index <= 3'(n);
         csr_wdata <= wdata;
         @(posedge clock);
         case (3'(n))
            CSR_PI_CODE:    cfg_shadow.pi_code          = wdata;
            CSR_PTY:        cfg_shadow.program_type     = wdata[4:0];
            CSR_TP:         cfg_shadow.traffic_program  = wdata[0];
            CSR_TA:         cfg_shadow.traffic_announce = wdata[0];
            CSR_MS:         cfg_shadow.music_speech     = wdata[0];
            CSR_ECC_ENABLE: cfg_shadow.ecc_enable       = wdata[0];
            CSR_ECC_VALUE:  cfg_shadow.ecc_value        = wdata[7:0];
            default:        cfg_shadow.tmc_enable       = wdata[0];
         endcase
      end
      csr_we <= 1'b0;
   endtask

   function automatic stim_row_type make_row(logic [1:0] op, logic [5:0] idx, logic [7:0] val,
                                             check_kind_type kind, logic b, logic g);
      stim_row_type r;
      r.op = op;
      r.idx = idx;
      r.val = val;
      r.kind = kind;
      r.exp_bit = b;
      r.exp_gs = g;
      return r;
   endfunction

   function automatic stim_row_type directed_row(int n);
      case (n)
         0:  return make_row(OP_TICK,   6'd0,  8'h00, CHECK_BIT,   1'b0, 1'b1);
         1:  return make_row(OP_TICK,   6'd63, 8'hFF, CHECK_MODEL, 1'b0, 1'b0);
         2:  return make_row(OP_UNUSED, 6'd63, 8'hFF, CHECK_NONE,  1'b0, 1'b0);
         3:  return make_row(OP_PS,     6'd8,  8'h55, CHECK_NONE,  1'b0, 1'b0);
         4:  return make_row(OP_PS,     6'd63, 8'hFF, CHECK_NONE,  1'b0, 1'b0);
         5:  return make_row(OP_PS,     6'd0,  8'h00, CHECK_NONE,  1'b0, 1'b0);
         6:  return make_row(OP_PS,     6'd7,  8'hFF, CHECK_NONE,  1'b0, 1'b0);
         7:  return make_row(OP_RT,     6'd0,  8'hFF, CHECK_NONE,  1'b0, 1'b0);
         8:  return make_row(OP_RT,     6'd63, 8'h00, CHECK_NONE,  1'b0, 1'b0);
         9:  return make_row(OP_RT,     6'd21, 8'hAA, CHECK_NONE,  1'b0, 1'b0);
         10: return make_row(OP_UNUSED, 6'd0,  8'h00, CHECK_NONE,  1'b0, 1'b0);
         11: return make_row(OP_TICK,   6'd0,  8'hFF, CHECK_MODEL, 1'b0, 1'b0);
         12: return make_row(OP_TICK,   6'd63, 8'h00, CHECK_MODEL, 1'b0, 1'b0);
         13: return make_row(OP_TICK,   6'd42, 8'h5A, CHECK_MODEL, 1'b0, 1'b0);
         14: return make_row(OP_TICK,   6'd21, 8'hA5, CHECK_MODEL, 1'b0, 1'b0);
         15: return make_row(OP_PS,     6'd63, 8'h00, CHECK_NONE,  1'b0, 1'b0);
         16: return make_row(OP_TICK,   6'd1,  8'h01, CHECK_MODEL, 1'b0, 1'b0);
         17: return make_row(OP_RT,     6'd32, 8'h7F, CHECK_NONE,  1'b0, 1'b0);
         18: return make_row(OP_TICK,   6'd62, 8'h80, CHECK_MODEL, 1'b0, 1'b0);
         default: return make_row(OP_TICK, 6'd0, 8'h00, CHECK_MODEL, 1'b0, 1'b0);
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bits.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: unexpected bit %b start %b", $realtime, rsp_bit_out,
                        rsp_group_start);
         end else begin
            seen_bit = pending_bits.pop_front();
            if (seen_bit.bit_out !== rsp_bit_out || seen_bit.group_start !== rsp_group_start)
            begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: bit exp %b got %b, start exp %b got %b", $realtime,
                           seen_bit.bit_out, rsp_bit_out, seen_bit.group_start,
                           rsp_group_start);
            end
         end
      end
   end

   initial begin
      int unsigned hold;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_calm) rsp_stall <= 1'b0;
         else begin
            hold = pick_gap();
            if (hold > 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(posedge clock);
               rsp_stall <= 1'b0;
            end
            repeat ($urandom_range(0, 6)) @(posedge clock);
         end
      end
   end

   initial begin
      stim_row_type row;
      cfg_type      c;
      int           phase;
      int           n;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = OP_TICK;
      req_char_index = '0;
      req_char_value = '0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      fail_count     = 0;
      req_calm       = 1'b0;
      rsp_calm       = 1'b0;
      cfg_shadow     = '0;
      slot_now       = '0;
      bitpos_now     = '0;
      for (n = 0; n < 8; n++) ps_chars[n] = SPACE_CHAR;
      for (n = 0; n < 64; n++) rt_chars[n] = SPACE_CHAR;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < N_DIRECTED; n++) begin
         row = directed_row(n);
         send_item(row.op, row.idx, row.val, row.kind, row.exp_bit, row.exp_gs);
      end

      for (phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         c = cfg_type'({$urandom, $urandom});
         req_calm = 1'b0;
         rsp_calm = 1'b0;
         case (phase)
            0: begin
               c = '1;
            end
            1: begin
               c.ecc_enable = 1'b0;
               c.tmc_enable = 1'b0;
            end
            2: begin
               c = '0;
               req_calm = 1'b1;
               rsp_calm = 1'b1;
            end
            3: begin
               c.ecc_enable = 1'b1;
               c.tmc_enable = 1'b0;
               rsp_calm = 1'b1;
            end
            4: begin
               c.ecc_enable = 1'b0;
               c.tmc_enable = 1'b1;
            end
            default: ;
         endcase
         program_settings(c);
         for (n = 0; n < PHASE_ITEMS; n++) send_random_item();
      end

      wait_idle();
      if (pending_bits.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/rdsgbg_pkg.sv
rtl/rdsgbg_rt_mem.sv
rtl/rdsgbg_crc_cell.sv
rtl/rdsgbg_seq.sv
rtl/rds_group_bitstream_generator_top.sv
dv/tb_top.sv
